// ===== sv/overwriting_sequenced_message_ring_macros.svh =====
// Assertion macros used by the message ring top module.
`ifndef OVERWRITING_SEQUENCED_MESSAGE_RING_MACROS_SVH
`define OVERWRITING_SEQUENCED_MESSAGE_RING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OMSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define OMSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/omsr_pkg.sv =====
// Types and codes shared by the message ring modules.
package omsr_pkg;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_PEEK  = 2'd1;
	localparam logic [1:0] OP_DUMP  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// Bit positions of the one-hot command kind.
	localparam int K_ADD   = 0;
	localparam int K_PEEK  = 1;
	localparam int K_DUMP  = 2;
	localparam int K_CLEAR = 3;

	localparam int NUM_KINDS = 4;
	localparam int CW = 48;

	typedef struct packed {
		logic [1:0]    operation;
		logic [31:0]   entry_data;
		logic [15:0]   client_tag;
		logic [CW-1:0] message_number;
	} req_t;

	typedef struct packed {
		logic          entry_valid;
		logic [31:0]   entry_word;
		logic [15:0]   entry_client;
		logic [CW-1:0] total_count;
		logic [CW-1:0] last_read_number;
		logic          last_of_run;
	} rsp_t;

	typedef struct packed {
		logic [NUM_KINDS-1:0] kind;
		logic [31:0]          data;
		logic [15:0]          tag;
		logic [CW-1:0]        number;
	} cmd_t;

endpackage

// ===== sv/omsr_front.sv =====
// Front end: decodes each request word and holds it in a two-entry command queue.
module omsr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  omsr_pkg::req_t    req,
	output logic              head_valid,
	output omsr_pkg::cmd_t    head_cmd,
	input  logic              pop
);

	localparam logic [1:0] QD = 2'd2;

	omsr_pkg::cmd_t queue_q [2];
	omsr_pkg::cmd_t dec;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           take;

	always_comb begin
		dec = '0;
		dec.data = req.entry_data;
		dec.tag = req.client_tag;
		dec.number = req.message_number;
		case (req.operation)
			omsr_pkg::OP_ADD:   dec.kind[omsr_pkg::K_ADD] = 1'b1;
			omsr_pkg::OP_PEEK:  dec.kind[omsr_pkg::K_PEEK] = 1'b1;
			omsr_pkg::OP_DUMP:  dec.kind[omsr_pkg::K_DUMP] = 1'b1;
			default:            dec.kind[omsr_pkg::K_CLEAR] = 1'b1;
		endcase
	end

	assign req_stall = (count_q == QD);
	assign head_valid = (count_q != 2'd0);
	assign head_cmd = queue_q[rd_ptr_q];
	assign push = req_valid & ~req_stall;
	assign take = pop & head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !take) begin
				count_q <= count_q + 2'd1;
			end else if (take && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== sv/omsr_back.sv =====
// Back end: ring state, entry memory, one-read-per-cycle sequencer and result register.
module omsr_back #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  omsr_pkg::cmd_t    head_cmd,
	output logic              pop,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output omsr_pkg::rsp_t    rsp
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = omsr_pkg::CW;
	localparam logic [FW-1:0] FULL = FW'(DEPTH);
	localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	logic [31:0]   word_mem [DEPTH];
	logic [15:0]   client_mem [DEPTH];

	logic [IW-1:0] oldest_q;
	logic [FW-1:0] fill_q;
	logic [CW-1:0] total_q;
	logic [FW-1:0] unread_q;
	logic [IW-1:0] cnt_q;

	logic          vld_s1;
	logic          ev_s1;
	logic          last_s1;
	logic [CW-1:0] total_s1;
	logic [CW-1:0] lrn_s1;
	logic [31:0]   word_s1;
	logic [15:0]   client_s1;

	omsr_pkg::rsp_t rsp_q;
	logic           rsp_vld_q;

	logic          out_free;
	logic          s1_adv;
	logic          issue;
	logic [CW-1:0] diff;
	logic          hit;
	logic          full;
	logic          dump_last;
	logic [FW-1:0] after;
	logic [IW:0]   k_sel;
	logic [IW:0]   slot_sum;
	logic [IW-1:0] slot;
	logic [IW-1:0] oldest_inc;
	logic [IW-1:0] oldest_n;
	logic [FW-1:0] fill_n;
	logic [CW-1:0] total_n;
	logic [FW-1:0] unread_n;
	logic [IW-1:0] cnt_n;
	logic          ev_n;
	logic          last_n;
	logic          do_write;
	logic          done;

	assign out_free = ~rsp_vld_q | ~rsp_stall;
	assign s1_adv = vld_s1 & out_free;
	assign issue = head_valid & (~vld_s1 | s1_adv);
	assign pop = issue & done;

	assign diff = total_q - head_cmd.number;
	assign hit = (diff != '0) && (diff <= CW'(fill_q));
	assign full = (fill_q == FULL);
	assign after = FW'(diff) - FW'(1);
	assign dump_last = (fill_q == '0) || ((FW'(cnt_q) + FW'(1)) == fill_q);
	assign oldest_inc = (oldest_q == LAST_IDX) ? '0 : oldest_q + IW'(1);

	// One offset from the oldest entry serves every access; < DEPTH unless a peek misses.
	always_comb begin
		if (head_cmd.kind[omsr_pkg::K_ADD]) begin
			k_sel = full ? '0 : (IW + 1)'(fill_q);
		end else if (head_cmd.kind[omsr_pkg::K_PEEK]) begin
			k_sel = (IW + 1)'(fill_q) - (IW + 1)'(diff);
		end else begin
			k_sel = (IW + 1)'(cnt_q);
		end
		slot_sum = {1'b0, oldest_q} + k_sel;
		slot = (slot_sum >= DEPTH_W) ? IW'(slot_sum - DEPTH_W) : slot_sum[IW-1:0];
	end

	always_comb begin
		oldest_n = oldest_q;
		fill_n = fill_q;
		total_n = total_q;
		unread_n = unread_q;
		cnt_n = cnt_q;
		ev_n = 1'b0;
		last_n = 1'b1;
		do_write = 1'b0;
		done = 1'b1;
		if (head_cmd.kind[omsr_pkg::K_ADD]) begin
			do_write = 1'b1;
			total_n = total_q + CW'(1);
			if (full) begin
				oldest_n = oldest_inc;
			end else begin
				fill_n = fill_q + FW'(1);
			end
			if (unread_q != FULL) begin
				unread_n = unread_q + FW'(1);
			end
		end else if (head_cmd.kind[omsr_pkg::K_PEEK]) begin
			ev_n = hit;
			if (hit && (unread_q > after)) begin
				unread_n = after;
			end
		end else if (head_cmd.kind[omsr_pkg::K_DUMP]) begin
			unread_n = '0;
			ev_n = (fill_q != '0);
			last_n = dump_last;
			done = dump_last;
			cnt_n = dump_last ? '0 : cnt_q + IW'(1);
		end else begin
			oldest_n = '0;
			fill_n = '0;
			total_n = '0;
			unread_n = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && do_write) begin
			word_mem[slot] <= head_cmd.data;
			client_mem[slot] <= head_cmd.tag;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			word_s1 <= word_mem[slot];
			client_s1 <= client_mem[slot];
			ev_s1 <= ev_n;
			last_s1 <= last_n;
			total_s1 <= total_n;
			lrn_s1 <= total_n - CW'(unread_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q <= '0;
			total_q <= '0;
			unread_q <= '0;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (issue) begin
				oldest_q <= oldest_n;
				fill_q <= fill_n;
				total_q <= total_n;
				unread_q <= unread_n;
				cnt_q <= cnt_n;
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.entry_valid <= ev_s1;
			rsp_q.entry_word <= ev_s1 ? word_s1 : '0;
			rsp_q.entry_client <= ev_s1 ? client_s1 : '0;
			rsp_q.total_count <= total_s1;
			rsp_q.last_read_number <= lrn_s1;
			rsp_q.last_of_run <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp = rsp_q;

endmodule

// ===== sv/overwriting_sequenced_message_ring.sv =====
// Overwriting message ring of DEPTH entries with add, peek, dump and clear commands.
// Request words enter a two-entry command queue and are carried out one at a time by a
// sequencer that owns the entry memory. Add, peek and clear each give one result; a
// dump gives one result per held entry (a single result when the ring is empty), read
// in turn through the single read port of the entry memory. A result passes a stage
// register and then the result register that drives the rsp port, and the queue keeps
// taking words while results wait to be taken, until both of its entries are held.
module overwriting_sequenced_message_ring #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  omsr_pkg::req_t    req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output omsr_pkg::rsp_t    rsp
);

	`include "overwriting_sequenced_message_ring_macros.svh"

	logic           head_valid;
	omsr_pkg::cmd_t head_cmd;
	logic           pop;

	omsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	omsr_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

	`OMSR_ASSERT_IMPL(a_kind_onehot, clk, arst_n, head_valid, $onehot(head_cmd.kind), "queued command kind is not one-hot")
	`OMSR_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, pop, head_valid, "command popped from an empty queue")
	`OMSR_ASSERT_IMPL(a_empty_entry_zero, clk, arst_n, rsp_valid && !rsp.entry_valid, (rsp.entry_word == '0) && (rsp.entry_client == '0), "result without entry carries entry bits")
	`OMSR_ASSERT_NEXT(a_full_holds, clk, arst_n, req_stall && !pop, req_stall, "queue lost an entry without a pop")

endmodule

// ===== tb/overwriting_sequenced_message_ring_tb.sv =====
// Self-checking testbench for the overwriting sequenced message ring.
module overwriting_sequenced_message_ring_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int RANDOM_WORDS = 400;
	localparam int QUIET_WORDS = 60;
	localparam int DRAIN_CYCLES = 20;

	class ring_scoreboard;
		logic [31:0] word_mem [DEPTH];
		logic [15:0] tag_mem [DEPTH];
		int unsigned oldest;
		int unsigned fill;
		int unsigned unread;
		logic [omsr_pkg::CW-1:0] total_msgs;
		omsr_pkg::rsp_t expected_q [$];
		int errors;

		function new();
			oldest = 0;
			fill = 0;
			unread = 0;
			total_msgs = '0;
			errors = 0;
		endfunction

		function void push_result(bit hit, int unsigned slot, bit last);
			omsr_pkg::rsp_t r;
			r.entry_valid = hit;
			r.entry_word = hit ? word_mem[slot] : '0;
			r.entry_client = hit ? tag_mem[slot] : '0;
			r.total_count = total_msgs;
			r.last_read_number = total_msgs - omsr_pkg::CW'(unread);
			r.last_of_run = last;
			expected_q.push_back(r);
		endfunction

		// Updates the ring state for one accepted word and queues its results.
		function void note_request(omsr_pkg::req_t w);
			int unsigned slot;
			logic [omsr_pkg::CW-1:0] diff;
			case (w.operation)
				omsr_pkg::OP_ADD: begin
					if (fill >= DEPTH) begin
						slot = oldest;
						oldest = (oldest + 1) % DEPTH;
					end else begin
						slot = (oldest + fill) % DEPTH;
						fill++;
					end
					word_mem[slot] = w.entry_data;
					tag_mem[slot] = w.client_tag;
					total_msgs = total_msgs + 1'b1;
					if (unread < DEPTH)
						unread++;
					push_result(1'b0, 0, 1'b1);
				end
				omsr_pkg::OP_PEEK: begin
					diff = total_msgs - w.message_number;
					if (diff >= 1 && diff <= fill) begin
						slot = (oldest + fill - int'(diff)) % DEPTH;
						if (unread > int'(diff) - 1)
							unread = int'(diff) - 1;
						push_result(1'b1, slot, 1'b1);
					end else begin
						push_result(1'b0, 0, 1'b1);
					end
				end
				omsr_pkg::OP_DUMP: begin
					unread = 0;
					if (fill == 0) begin
						push_result(1'b0, 0, 1'b1);
					end else begin
						for (int unsigned i = 0; i < fill; i++)
							push_result(1'b1, (oldest + i) % DEPTH, i + 1 == fill);
					end
				end
				default: begin
					oldest = 0;
					fill = 0;
					unread = 0;
					total_msgs = '0;
					push_result(1'b0, 0, 1'b1);
				end
			endcase
		endfunction

		function void compare_field(string name, logic [omsr_pkg::CW-1:0] exp_v,
				logic [omsr_pkg::CW-1:0] got_v);
			if (got_v !== exp_v) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_response(omsr_pkg::rsp_t got);
			omsr_pkg::rsp_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			compare_field("entry_valid", exp_r.entry_valid, got.entry_valid);
			compare_field("entry_word", exp_r.entry_word, got.entry_word);
			compare_field("entry_client", exp_r.entry_client, got.entry_client);
			compare_field("total_count", exp_r.total_count, got.total_count);
			compare_field("last_read_number", exp_r.last_read_number, got.last_read_number);
			compare_field("last_of_run", exp_r.last_of_run, got.last_of_run);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	omsr_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	omsr_pkg::rsp_t rsp;

	ring_scoreboard sb = new();
	bit quiet = 1'b0;

	overwriting_sequenced_message_ring #(
		.DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic omsr_pkg::req_t build_word(logic [1:0] op, logic [31:0] data,
			logic [15:0] tag, logic [omsr_pkg::CW-1:0] num);
		omsr_pkg::req_t w;
		w.operation = op;
		w.entry_data = data;
		w.client_tag = tag;
		w.message_number = num;
		return w;
	endfunction

	// Mostly adds and peeks close to the held range, so that hits and overwrites are common.
	function automatic omsr_pkg::req_t random_word();
		omsr_pkg::req_t w;
		int pick;
		w.entry_data = $urandom;
		w.client_tag = 16'($urandom);
		w.message_number = {16'($urandom), 32'($urandom)};
		pick = $urandom_range(0, 99);
		if (pick < 48) begin
			w.operation = omsr_pkg::OP_ADD;
		end else if (pick < 85) begin
			w.operation = omsr_pkg::OP_PEEK;
			if ($urandom_range(0, 4) != 0)
				w.message_number = sb.total_msgs
					- omsr_pkg::CW'($urandom_range(0, sb.fill + 2));
		end else if (pick < 97) begin
			w.operation = omsr_pkg::OP_DUMP;
		end else begin
			w.operation = omsr_pkg::OP_CLEAR;
		end
		return w;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(omsr_pkg::req_t w);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_valid = 1'b1;
		req = w;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(w);
		@(negedge clk);
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 4);
			if (stall_left > 0) begin
				rsp_stall = 1'b1;
				stall_left--;
			end else begin
				rsp_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty ring: dump and peek give a single empty word.
		send_word(build_word(omsr_pkg::OP_DUMP, 32'h0, 16'h0, '0));
		send_word(build_word(omsr_pkg::OP_PEEK, 32'hFFFF_FFFF, 16'hFFFF, '0));
		send_word(build_word(omsr_pkg::OP_ADD, 32'h0, 16'h0, '0));
		send_word(build_word(omsr_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, '1));
		send_word(build_word(omsr_pkg::OP_PEEK, 32'h0, 16'h0, 48'd0));
		// A number equal to the total and the all-ones number are both beyond the newest.
		send_word(build_word(omsr_pkg::OP_PEEK, 32'h0, 16'h0, 48'd2));
		send_word(build_word(omsr_pkg::OP_PEEK, 32'h0, 16'h0, '1));
		send_word(build_word(omsr_pkg::OP_DUMP, 32'h0, 16'h0, '0));
		send_word(build_word(omsr_pkg::OP_CLEAR, 32'h0, 16'h0, '0));
		// One add past full overwrites message 0.
		for (int i = 0; i < DEPTH + 1; i++)
			send_word(build_word(omsr_pkg::OP_ADD, $urandom, 16'($urandom), '0));
		send_word(build_word(omsr_pkg::OP_PEEK, 32'h0, 16'h0, 48'd0));
		send_word(build_word(omsr_pkg::OP_PEEK, 32'h0, 16'h0, 48'd1));
		send_word(build_word(omsr_pkg::OP_DUMP, 32'h0, 16'h0, '0));
		send_word(build_word(omsr_pkg::OP_CLEAR, 32'h0, 16'h0, '0));

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS - QUIET_WORDS)
				quiet = 1'b1;
			send_word(random_word());
		end
		req_valid = 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
